FILE: sv/tchd_pkg.sv
// Package for traction correction hold/decay block: shared types and constants.
// No dependencies.
`default_nettype none
package tchd_pkg;
    localparam int unsigned DT_MAX_US = 100000;
    localparam logic [26:0] DECAY_SAT = 27'h7FFFFFF;

    localparam logic [2:0] REG_USE_MULT = 3'd0;
    localparam logic [2:0] REG_MIN_SPEED = 3'd1;
    localparam logic [2:0] REG_MIN_PEDAL = 3'd2;
    localparam logic [2:0] REG_CHECK = 3'd3;
    localparam logic [2:0] REG_HOLD = 3'd4;
    localparam logic [2:0] REG_DECAY = 3'd5;

    typedef struct packed {
        logic load;   // capture input item, start scaling
        logic mul;    // multiply step for lane sel
        logic [1:0] sel;
        logic gate;   // gating, timers, check
        logic div_start;
        logic div_step;
        logic finish; // ramp result into output register
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic need_div;
    } t_status;
endpackage
`default_nettype wire

FILE: sv/tchd_ctrl.sv
// Controller for traction correction hold/decay: sequences load, multiply,
// gate, divide and output steps. Depends on tchd_pkg.
`default_nettype none
module tchd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_fire,
    input  wire logic             i_out_free,
    input  wire tchd_pkg::t_status i_status,
    output tchd_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);
    import tchd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_GATE = 7'b0000100,
        S_DST  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sel <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel = r_sel;
        o_cmd = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_sel = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_sel == 2'd2) begin
                    n_state = S_GATE;
                end else begin
                    n_sel = r_sel + 2'd1;
                end
            end
            S_GATE: begin
                o_cmd.gate = 1'b1;
                n_state = S_DST;
            end
            S_DST: begin
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_fin_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> $past(r_state == S_WAIT)) else $error("finish without wait");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cmd.load) else $error("load while busy");
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3) else $error("bad lane select");
endmodule
`default_nettype wire

FILE: sv/tchd_dp.sv
// Datapath for traction correction hold/decay: scaling, gating, timers,
// held values and a shared restoring divider for the ramp. Depends on tchd_pkg.
`default_nettype none
module tchd_dp #(
    parameter int unsigned FAST_PERIOD_MS = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tchd_pkg::t_cmd i_cmd,
    input  wire logic [134:0]  i_item,
    input  wire logic          i_use_mult,
    input  wire logic [7:0]    i_min_speed,
    input  wire logic [6:0]    i_min_pedal,
    input  wire logic [15:0]   i_check_ms,
    input  wire logic [15:0]   i_hold_ms,
    input  wire logic [15:0]   i_decay_ms,
    output tchd_pkg::t_status  o_status,
    output logic [49:0]        o_result
);
    import tchd_pkg::*;

    localparam int DIVW = 44;  // |diff|(17) * t(27)

    logic [23:0] r_dt;
    logic [15:0] r_speed;
    logic signed [15:0] r_slip;
    logic [14:0] r_pedal;
    logic signed [15:0] r_raw [3];
    logic signed [15:0] r_mult;

    logic [31:0] r_chk;
    logic [26:0] r_hold, r_dec;
    logic signed [15:0] r_last, r_held [3], r_tgt [3], r_app [3];
    logic r_active, r_need;
    logic [26:0] r_t, r_d;

    // divider state
    logic [1:0]  r_lane;
    logic [5:0]  r_bit;
    logic [DIVW-1:0] r_num;
    logic [27:0] r_rem;
    logic [DIVW-1:0] r_quo;
    logic        r_neg, r_done;

    logic signed [31:0] prod;
    logic signed [31:0] rnd;
    logic signed [15:0] scl;
    assign prod = r_raw[i_cmd.sel] * r_mult;
    assign rnd = (prod + 32'sd2048) >>> 12;
    assign scl = (rnd > 32'sd32767) ? 16'sd32767 :
                 (rnd < -32'sd32768) ? -16'sd32768 : rnd[15:0];

    // gating and timers
    logic [23:0] dt;
    logic gated, act;
    logic signed [15:0] g [3];
    logic [31:0] period_us;
    logic [15:0] pms;
    logic fire, latch, upd_now;
    logic [26:0] hold_a, hold_b, dec_a, dec_b, d_us, t_v;
    logic [27:0] dec_sum;
    logic [23:0] tfd;

    always_comb begin
        dt = (r_dt > 24'(DT_MAX_US)) ? 24'(DT_MAX_US) : r_dt;
        gated = ((i_min_speed != 8'd0) && (r_speed < {i_min_speed, 8'd0})) ||
                ((i_min_pedal != 7'd0) && (r_pedal < {i_min_pedal, 8'd0}));
        g[0] = (!gated && r_raw[0] > 16'sd0) ? -r_raw[0] : 16'sd0;
        g[1] = (!gated && r_raw[1] > 16'sd0) ? -r_raw[1] : 16'sd0;
        g[2] = gated ? 16'sd0 : r_raw[2];
        act = (g[0] != 0) || (g[1] != 0) || (g[2] != 0);
        pms = (i_check_ms < 16'(FAST_PERIOD_MS)) ? 16'(FAST_PERIOD_MS) : i_check_ms;
        period_us = 32'(pms) * 32'd1000;
        fire = (r_chk <= 32'(dt));
        latch = fire && act && (r_slip > r_last);
        hold_a = latch ? 27'(i_hold_ms * 27'd1000) : r_hold;
        dec_a = latch ? 27'd0 : r_dec;
        tfd = 24'd0;
        hold_b = hold_a;
        dec_b = dec_a;
        if (hold_a != 27'd0) begin
            if (27'(dt) >= hold_a) begin
                tfd = 24'(27'(dt) - hold_a);
                hold_b = 27'd0;
            end else begin
                hold_b = hold_a - 27'(dt);
                dec_b = 27'd0;
            end
        end else begin
            tfd = dt;
        end
        d_us = 27'(i_decay_ms * 27'd1000);
        dec_sum = 28'(dec_b) + 28'(tfd);
        t_v = 27'd0;
        if (hold_b == 27'd0) begin
            if (i_decay_ms != 16'd0) begin
                dec_b = (dec_sum > 28'(DECAY_SAT)) ? DECAY_SAT : dec_sum[26:0];
                t_v = (dec_b < d_us) ? dec_b : d_us;
            end else begin
                dec_b = 27'd0;
            end
        end
    end

    // ramp already at its end (or no ramp): targets go straight out
    assign upd_now = (hold_b == 27'd0) && ((i_decay_ms == 16'd0) || (t_v >= d_us));

    // lane whose difference feeds the next divider load
    logic [1:0] div_lane;
    assign div_lane = i_cmd.div_start ? 2'd0 : ((r_lane == 2'd0) ? 2'd1 : 2'd2);

    logic signed [16:0] diff;
    logic [16:0] mag;
    assign diff = 17'(r_tgt[div_lane]) - 17'(r_held[div_lane]);
    assign mag = diff[16] ? 17'(-diff) : diff;

    logic [27:0] trial;
    assign trial = {r_rem[26:0], r_num[DIVW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= '0; r_hold <= '0; r_dec <= '0; r_last <= '0;
            for (int k = 0; k < 3; k++) r_held[k] <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_dt <= i_item[23:0];
                r_speed <= i_item[39:24];
                r_slip <= i_item[55:40];
                r_pedal <= i_item[70:56];
                r_raw[0] <= i_item[86:71];
                r_raw[1] <= i_item[102:87];
                r_raw[2] <= i_item[118:103];
                r_mult <= i_item[134:119];
            end
            if (i_cmd.mul && i_use_mult) r_raw[i_cmd.sel] <= scl;
            if (i_cmd.gate) begin
                r_chk <= fire ? period_us : r_chk - 32'(dt);
                if (fire) r_last <= r_slip;
                r_hold <= hold_b;
                r_dec <= dec_b;
                r_active <= act;
                for (int k = 0; k < 3; k++) begin
                    r_tgt[k] <= g[k];
                    if (latch || upd_now) r_held[k] <= g[k];
                    r_app[k] <= (latch || upd_now) ? g[k] : r_held[k];
                end
                r_need <= (hold_b == 27'd0) && !upd_now;
                r_t <= t_v;
                r_d <= d_us;
            end
            if (i_cmd.div_start) begin
                r_lane <= 2'd0;
                r_done <= 1'b0;
                r_bit <= 6'd0;
                r_num <= 44'(mag) * 44'(r_t);
                r_neg <= diff[16];
                r_rem <= '0;
                r_quo <= '0;
            end
            if (i_cmd.div_step && !r_done) begin
                if (r_bit == 6'(DIVW)) begin
                    r_app[r_lane] <= 16'(17'(r_held[r_lane]) +
                        (r_neg ? -17'(r_quo) : 17'(r_quo)));
                    if (r_lane == 2'd2) begin
                        r_done <= 1'b1;
                    end else begin
                        r_lane <= r_lane + 2'd1;
                        r_bit <= 6'd0;
                        r_num <= 44'(mag) * 44'(r_t);
                        r_neg <= diff[16];
                        r_rem <= '0;
                        r_quo <= '0;
                    end
                end else begin
                    r_num <= r_num << 1;
                    r_bit <= r_bit + 6'd1;
                    if (trial >= 28'(r_d)) begin
                        r_rem <= trial - 28'(r_d);
                        r_quo <= {r_quo[DIVW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[DIVW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_status.need_div = r_need;
    assign o_status.div_done = r_done;
    assign o_result = {(r_hold != 27'd0), r_active, r_app[2], r_app[1], r_app[0]};
endmodule
`default_nettype wire

FILE: sv/traction_correction_hold_decay_top.sv
// Top level of traction correction hold/decay: stream ports, APB register file,
// output register. Depends on tchd_pkg, tchd_ctrl, tchd_dp.
//
// channel | dir | handshake             | payload
// s_axis  | in  | tvalid/tready         | 135b item
// m_axis  | out | tvalid/tready         | 50b result
// apb     | in  | psel/penable/pwrite   | 6 registers, 32b data
//
// An item runs load, multiply, gate and output steps; when a decay ramp runs, the
// restoring divider (one quotient bit a cycle, three lanes) runs before output.
// Reset is synchronous; the APB registers read as zero after it and the controller goes idle.
// The next item is taken while a result waits; a stalled result holds.
`default_nettype none
module traction_correction_hold_decay_top #(
    parameter int unsigned FAST_PERIOD_MS = 5
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // elapsed_us, speed, slip, pedal, throttle_table, timing_table, skip_table,
    // multiplier (low bit up), 1 pad bit
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // throttle_correction, timing_correction, skip_correction, active, holding
    output logic [55:0]       m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tchd_pkg::*;

    logic r_use; logic [7:0] r_ms; logic [6:0] r_mp;
    logic [15:0] r_ck, r_hd, r_dc;
    logic [2:0] idx;
    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0; r_ms <= '0; r_mp <= '0; r_ck <= '0; r_hd <= '0; r_dc <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_USE_MULT:  r_use <= pwdata[0];
                REG_MIN_SPEED: r_ms <= pwdata[7:0];
                REG_MIN_PEDAL: r_mp <= pwdata[6:0];
                REG_CHECK:     r_ck <= pwdata[15:0];
                REG_HOLD:      r_hd <= pwdata[15:0];
                REG_DECAY:     r_dc <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_USE_MULT:  prdata = {31'd0, r_use};
            REG_MIN_SPEED: prdata = {24'd0, r_ms};
            REG_MIN_PEDAL: prdata = {25'd0, r_mp};
            REG_CHECK:     prdata = {16'd0, r_ck};
            REG_HOLD:      prdata = {16'd0, r_hd};
            REG_DECAY:     prdata = {16'd0, r_dc};
            default:       prdata = 32'd0;
        endcase
    end

    t_cmd cmd;
    t_status st;
    logic busy;
    logic [49:0] res;
    logic r_ov;
    logic [49:0] r_od;

    assign s_axis_tready = !busy;

    tchd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_free(!r_ov || m_axis_tready),
        .i_status(st), .o_cmd(cmd), .o_busy(busy)
    );

    tchd_dp #(.FAST_PERIOD_MS(FAST_PERIOD_MS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(s_axis_tdata[134:0]),
        .i_use_mult(r_use), .i_min_speed(r_ms), .i_min_pedal(r_mp),
        .i_check_ms(r_ck), .i_hold_ms(r_hd), .i_decay_ms(r_dc),
        .o_status(st), .o_result(res)
    );

    // output register loads at finish; the datapath result is already final then
    logic r_fin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_fin <= cmd.finish;
            if (cmd.finish) r_od <= res;
            if (cmd.finish) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {6'd0, r_od};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("lost result");
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !cmd.finish) else $error("double finish");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> s_axis_tready) else $error("not ready after finish");
endmodule
`default_nettype wire
